[rtl/core/rgb_to_yuv420_converter_assert.svh]
// Assertion macros shared by the converter RTL.
// Needs nothing but a clock and an active-low reset in the caller.
`ifndef RGB_TO_YUV420_CONVERTER_ASSERT_SVH
`define RGB_TO_YUV420_CONVERTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RGBYUV_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define RGBYUV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/rgbyuv_pkg.sv]
// Types, coefficients and register codes for the RGB to YUV 4:2:0 converter.
// No dependencies.
`default_nettype none

package rgbyuv_pkg;

	localparam int CFG_W   = 13;
	localparam int FRAC_W  = 18;
	localparam int COEF_W  = 18;
	localparam int PROD_W  = 26;
	localparam int SUM_W   = 28;

	localparam logic [COEF_W-1:0] COEF_Y_R  = 18'd67316;
	localparam logic [COEF_W-1:0] COEF_Y_G  = 18'd132154;
	localparam logic [COEF_W-1:0] COEF_Y_B  = 18'd25666;
	localparam logic [COEF_W-1:0] COEF_CB_R = 18'd38856;
	localparam logic [COEF_W-1:0] COEF_CB_G = 18'd76282;
	localparam logic [COEF_W-1:0] COEF_CB_B = 18'd115138;
	localparam logic [COEF_W-1:0] COEF_CR_R = 18'd115138;
	localparam logic [COEF_W-1:0] COEF_CR_G = 18'd96414;
	localparam logic [COEF_W-1:0] COEF_CR_B = 18'd18724;

	localparam logic [7:0]             LUMA_OFFSET = 8'd16;
	localparam logic signed [SUM_W-1:0] CHROMA_BIAS = 28'sd33554432;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd1920;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd1080;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam int ADDR_W = 3;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] chroma_blue;
		logic [7:0] chroma_red;
		logic       chroma_valid;
		logic       frame_end;
	} result_t;

	typedef struct packed {
		pixel_t px;
		logic   chroma_valid;
		logic   frame_end;
	} qentry_t;

endpackage

`default_nettype wire

[rtl/core/rgbyuv_stream_if.sv]
// Valid/ready stream channel carrying one payload word per handshake.
// Payload type is a parameter; used with rgbyuv_pkg types.
`default_nettype none

interface rgbyuv_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/rgbyuv_front.sv]
// Front end: accepts pixel words, tracks column/row, tags chroma and frame end.
// Depends on rgbyuv_pkg and rgbyuv_stream_if; pushes into rgbyuv_queue.
`default_nettype none
`include "rgb_to_yuv420_converter_assert.svh"

module rgbyuv_front #(
	parameter int MAX_DIMENSION = 4096
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [rgbyuv_pkg::CFG_W-1:0]    frame_width,
	input  wire logic [rgbyuv_pkg::CFG_W-1:0]    frame_height,
	rgbyuv_stream_if.sink                        pixel,
	input  wire logic                            q_full,
	output logic                                 push,
	output rgbyuv_pkg::qentry_t                  entry
);
	localparam int PW = (MAX_DIMENSION > 2) ? $clog2(MAX_DIMENSION) : 1;
	localparam int SW = $clog2(MAX_DIMENSION + 1);
	localparam int XW = (SW > rgbyuv_pkg::CFG_W) ? SW : rgbyuv_pkg::CFG_W;

	logic [PW-1:0] col_q, row_q;
	logic [XW-1:0] w_ext, h_ext, eff_w, eff_h;
	logic [XW:0]   col_next, row_next;
	logic          last_col, last_row, accept;

	assign pixel.ready = !q_full;
	assign accept      = pixel.valid && pixel.ready;

	always_comb begin
		w_ext = XW'(frame_width);
		h_ext = XW'(frame_height);
		if (w_ext == '0) begin
			eff_w = XW'(1);
		end else if (w_ext > XW'(MAX_DIMENSION)) begin
			eff_w = XW'(MAX_DIMENSION);
		end else begin
			eff_w = w_ext;
		end
		if (h_ext == '0) begin
			eff_h = XW'(1);
		end else if (h_ext > XW'(MAX_DIMENSION)) begin
			eff_h = XW'(MAX_DIMENSION);
		end else begin
			eff_h = h_ext;
		end
		col_next = (XW + 1)'(col_q) + (XW + 1)'(1);
		row_next = (XW + 1)'(row_q) + (XW + 1)'(1);
		last_col = col_next >= {1'b0, eff_w};
		last_row = row_next >= {1'b0, eff_h};
	end

	assign push               = accept;
	assign entry.px           = pixel.data;
	assign entry.chroma_valid = !col_q[0] && !row_q[0];
	assign entry.frame_end    = last_col && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : PW'(row_next);
			end else begin
				col_q <= PW'(col_next);
			end
		end
	end

	`RGBYUV_ASSERT_NEXT(a_frame_end_wraps, clk, arst_n, accept && entry.frame_end,
		col_q == '0 && row_q == '0)
	`RGBYUV_ASSERT_NEXT(a_col_advances, clk, arst_n, accept && !last_col,
		col_q == PW'($past(col_q) + PW'(1)) && row_q == $past(row_q))

endmodule

`default_nettype wire

[rtl/core/rgbyuv_queue.sv]
// Short register queue between the front end and the arithmetic back end.
// Depends on rgbyuv_pkg.
`default_nettype none
`include "rgb_to_yuv420_converter_assert.svh"

module rgbyuv_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire rgbyuv_pkg::qentry_t entry,
	output logic                     full,
	input  wire logic                pop,
	output rgbyuv_pkg::qentry_t      head,
	output logic                     not_empty
);
	rgbyuv_pkg::qentry_t mem_q [rgbyuv_pkg::QUEUE_DEPTH];
	logic [rgbyuv_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [rgbyuv_pkg::QCNT_W-1:0] count_q;

	assign full      = count_q == rgbyuv_pkg::QCNT_W'(rgbyuv_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + rgbyuv_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + rgbyuv_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + rgbyuv_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - rgbyuv_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`RGBYUV_ASSERT_IMPLY(a_no_overflow_underflow, clk, arst_n, push || pop,
		!(push && full && !pop) && !(pop && !not_empty))

endmodule

`default_nettype wire

[rtl/core/rgbyuv_back.sv]
// Back end: pops tagged pixels, multiplies by BT.601 coefficients, sums and offsets.
// Depends on rgbyuv_pkg and rgbyuv_stream_if; fed by rgbyuv_queue.
`default_nettype none
`include "rgb_to_yuv420_converter_assert.svh"

module rgbyuv_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rgbyuv_pkg::qentry_t head,
	input  wire logic                not_empty,
	output logic                     pop,
	rgbyuv_stream_if.source          result
);
	localparam int PW = rgbyuv_pkg::PROD_W;
	localparam int SW = rgbyuv_pkg::SUM_W;

	logic          v_s1, v_s2, rdy_s1, rdy_s2;
	logic [PW-1:0] yr_s1, yg_s1, yb_s1, cbr_s1, cbg_s1, cbb_s1, crr_s1, crg_s1, crb_s1;
	logic          cv_s1, fe_s1;
	rgbyuv_pkg::result_t res_s2, res_d;
	logic signed [SW-1:0] ysum, cbsum, crsum;

	assign rdy_s2 = !v_s2 || result.ready;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign pop    = not_empty && rdy_s1;

	always_ff @(posedge clk) begin
		if (pop) begin
			yr_s1  <= PW'(head.px.red)   * PW'(rgbyuv_pkg::COEF_Y_R);
			yg_s1  <= PW'(head.px.green) * PW'(rgbyuv_pkg::COEF_Y_G);
			yb_s1  <= PW'(head.px.blue)  * PW'(rgbyuv_pkg::COEF_Y_B);
			cbr_s1 <= PW'(head.px.red)   * PW'(rgbyuv_pkg::COEF_CB_R);
			cbg_s1 <= PW'(head.px.green) * PW'(rgbyuv_pkg::COEF_CB_G);
			cbb_s1 <= PW'(head.px.blue)  * PW'(rgbyuv_pkg::COEF_CB_B);
			crr_s1 <= PW'(head.px.red)   * PW'(rgbyuv_pkg::COEF_CR_R);
			crg_s1 <= PW'(head.px.green) * PW'(rgbyuv_pkg::COEF_CR_G);
			crb_s1 <= PW'(head.px.blue)  * PW'(rgbyuv_pkg::COEF_CR_B);
			cv_s1  <= head.chroma_valid;
			fe_s1  <= head.frame_end;
		end
	end

	always_comb begin
		ysum  = $signed(SW'(yr_s1)) + $signed(SW'(yg_s1)) + $signed(SW'(yb_s1));
		cbsum = rgbyuv_pkg::CHROMA_BIAS - $signed(SW'(cbr_s1)) - $signed(SW'(cbg_s1))
			+ $signed(SW'(cbb_s1));
		crsum = rgbyuv_pkg::CHROMA_BIAS + $signed(SW'(crr_s1)) - $signed(SW'(crg_s1))
			- $signed(SW'(crb_s1));
		res_d.luma         = ysum[rgbyuv_pkg::FRAC_W +: 8] + rgbyuv_pkg::LUMA_OFFSET;
		res_d.chroma_blue  = cv_s1 ? cbsum[rgbyuv_pkg::FRAC_W +: 8] : 8'd0;
		res_d.chroma_red   = cv_s1 ? crsum[rgbyuv_pkg::FRAC_W +: 8] : 8'd0;
		res_d.chroma_valid = cv_s1;
		res_d.frame_end    = fe_s1;
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			res_s2 <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= pop;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	assign result.valid = v_s2;
	assign result.data  = res_s2;

	`RGBYUV_ASSERT_IMPLY(a_no_chroma_off_grid, clk, arst_n,
		result.valid && !result.data.chroma_valid,
		result.data.chroma_blue == 8'd0 && result.data.chroma_red == 8'd0)
	`RGBYUV_ASSERT_IMPLY(a_luma_studio_range, clk, arst_n, result.valid,
		result.data.luma >= 8'd16 && result.data.luma <= 8'd235)

endmodule

`default_nettype wire

[rtl/core/rgb_to_yuv420_converter.sv]
// RGB to YUV 4:2:0 converter, BT.601 studio range; top level with APB registers.
// A result is registered through the queue write, multiply and sum stages after pixel accept.
// Throughput: one pixel per cycle while result.ready holds; set by the one-entry-per-cycle queue pop.
// A 4-word queue decouples the position tracker from the multiply pipeline.
// Reset (arst_n low, async): counters at origin, queue and pipeline empty,
// frame size 1920 x 1080.
`default_nettype none

module rgb_to_yuv420_converter #(
	parameter int MAX_DIMENSION = 4096
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	rgbyuv_stream_if.sink                         pixel,
	rgbyuv_stream_if.source                       result,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [rgbyuv_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [31:0]                      pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);
	logic [rgbyuv_pkg::CFG_W-1:0] frame_width_q, frame_height_q;
	rgbyuv_pkg::reg_idx_t reg_idx;
	rgbyuv_pkg::qentry_t  entry, head;
	logic push, pop, q_full, not_empty, wr_en;

	assign pready  = 1'b1;
	assign reg_idx = rgbyuv_pkg::reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= rgbyuv_pkg::FRAME_WIDTH_RESET;
			frame_height_q <= rgbyuv_pkg::FRAME_HEIGHT_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				rgbyuv_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[rgbyuv_pkg::CFG_W-1:0];
				rgbyuv_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[rgbyuv_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rgbyuv_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
			rgbyuv_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			default:                      prdata = '0;
		endcase
	end

	rgbyuv_front #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_width (frame_width_q),
		.frame_height(frame_height_q),
		.pixel       (pixel),
		.q_full      (q_full),
		.push        (push),
		.entry       (entry)
	);

	rgbyuv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.entry    (entry),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.not_empty(not_empty)
	);

	rgbyuv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.not_empty(not_empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

`default_nettype wire
